[hw/rtl/http_chunked_response_splitter_assert.svh]
// Assertion macros used by the splitter core.
`ifndef HTTP_CHUNKED_RESPONSE_SPLITTER_ASSERT_SVH
`define HTTP_CHUNKED_RESPONSE_SPLITTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HCRS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define HCRS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/hcrs_pkg.sv]
// Shared types, constants and lookup functions of the chunked response splitter.
package hcrs_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Length of the "Transfer-Encoding: chunked" header line
   localparam logic [4:0] TE_LEN = 5'd26;

   // Raw bytes that follow a chunk's data (the CR LF trailer)
   localparam int CHUNK_TRAILER_LEN = 2;

   // Output queue depth
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       part;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // Character of the chunked header line at a given position
   function automatic logic [7:0] te_char(input logic [4:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:  c = "T";
         5'd1:  c = "r";
         5'd2:  c = "a";
         5'd3:  c = "n";
         5'd4:  c = "s";
         5'd5:  c = "f";
         5'd6:  c = "e";
         5'd7:  c = "r";
         5'd8:  c = "-";
         5'd9:  c = "E";
         5'd10: c = "n";
         5'd11: c = "c";
         5'd12: c = "o";
         5'd13: c = "d";
         5'd14: c = "i";
         5'd15: c = "n";
         5'd16: c = "g";
         5'd17: c = ":";
         5'd18: c = " ";
         5'd19: c = "c";
         5'd20: c = "h";
         5'd21: c = "u";
         5'd22: c = "n";
         5'd23: c = "k";
         5'd24: c = "e";
         5'd25: c = "d";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Decode one ASCII hex digit
   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.ok    = 1'b0;
      h.value = 4'd0;
      if (b >= "0" && b <= "9") begin
         h.ok    = 1'b1;
         h.value = 4'(b - "0");
      end else if (b >= "a" && b <= "f") begin
         h.ok    = 1'b1;
         h.value = 4'(b - "a" + 8'd10);
      end else if (b >= "A" && b <= "F") begin
         h.ok    = 1'b1;
         h.value = 4'(b - "A" + 8'd10);
      end
      return h;
   endfunction

endpackage

[hw/rtl/hcrs_core.sv]
// Input register, framing state and per-word decode of the chunked response splitter.
`include "http_chunked_response_splitter_assert.svh"

module hcrs_core #(
   parameter int SIZE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   input  logic                  space_ok,
   output logic [1:0]            push_cnt,
   output hcrs_pkg::result_type  push0,
   output hcrs_pkg::result_type  push1
);

   localparam logic [2:0] MODE_HDR   = 3'd0;
   localparam logic [2:0] MODE_PLAIN = 3'd1;
   localparam logic [2:0] MODE_SIZE  = 3'd2;
   localparam logic [2:0] MODE_DATA  = 3'd3;
   localparam logic [2:0] MODE_FINAL = 3'd4;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // Framing state
   logic [2:0]           mode_ff, mode_in;
   logic                 held_cr_ff, held_cr_in;
   logic                 line_nonempty_ff, line_nonempty_in;
   logic [4:0]           match_index_ff, match_index_in;
   logic                 match_failed_ff, match_failed_in;
   logic                 chunked_seen_ff, chunked_seen_in;
   logic [SIZE_BITS-1:0] size_accum_ff, size_accum_in;
   logic                 hex_done_ff, hex_done_in;
   logic                 size_line_cr_ff, size_line_cr_in;
   logic [SIZE_BITS:0]   pass_count_ff, pass_count_in;

   logic                 fire;
   logic [1:0]           n_res;
   hcrs_pkg::result_type res [2];

   assign fire     = in_valid_ff && space_ok;
   assign in_ready = !in_valid_ff || space_ok;

   // Hold the word until the decode stage takes it
   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_ready) begin
         in_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
   end

   // Decode one word: header folding, plain body, size lines, chunk data, end flush
   always_comb begin
      logic                   skip;
      logic                   do_fold;
      logic                   part;
      logic [SIZE_BITS+3:0]   ext;
      logic [SIZE_BITS:0]     pc;
      hcrs_pkg::hex_type      hx;

      mode_in          = mode_ff;
      held_cr_in       = held_cr_ff;
      line_nonempty_in = line_nonempty_ff;
      match_index_in   = match_index_ff;
      match_failed_in  = match_failed_ff;
      chunked_seen_in  = chunked_seen_ff;
      size_accum_in    = size_accum_ff;
      hex_done_in      = hex_done_ff;
      size_line_cr_in  = size_line_cr_ff;
      pass_count_in    = pass_count_ff;
      res[0]           = '0;
      res[1]           = '0;
      n_res            = 2'd0;
      skip             = 1'b0;
      do_fold          = 1'b0;
      part             = 1'b0;
      ext              = {size_accum_ff, 4'd0};
      pc               = pass_count_ff;
      hx               = hcrs_pkg::hex_decode(byte_ff);

      case (mode_ff)
         MODE_HDR: begin
            if (held_cr_ff) begin
               held_cr_in = 1'b0;
               if (byte_ff == hcrs_pkg::CH_LF) begin
                  // End of a header line
                  if (!match_failed_ff && match_index_ff == hcrs_pkg::TE_LEN) begin
                     chunked_seen_in = 1'b1;
                  end
                  line_nonempty_in = 1'b0;
                  match_index_in   = 5'd0;
                  match_failed_in  = 1'b0;
                  res[n_res[0]]    = '{hcrs_pkg::CH_LF, 1'b1, 1'b0, 1'b0};
                  n_res            = n_res + 2'd1;
                  if (!line_nonempty_ff) begin
                     mode_in         = chunked_seen_in ? MODE_SIZE : MODE_PLAIN;
                     size_accum_in   = '0;
                     hex_done_in     = 1'b0;
                     size_line_cr_in = 1'b0;
                  end
                  skip = 1'b1;
               end else begin
                  // Lone CR is an ordinary line character
                  line_nonempty_in = 1'b1;
                  if (!match_failed_in && match_index_in < hcrs_pkg::TE_LEN &&
                      hcrs_pkg::CH_CR == hcrs_pkg::te_char(match_index_in)) begin
                     match_index_in = match_index_in + 5'd1;
                  end else begin
                     match_failed_in = 1'b1;
                  end
                  res[n_res[0]] = '{hcrs_pkg::CH_CR, 1'b1, 1'b0, 1'b0};
                  n_res         = n_res + 2'd1;
               end
            end
            if (!skip) begin
               if (byte_ff == hcrs_pkg::CH_CR) begin
                  held_cr_in = 1'b1;
               end else begin
                  line_nonempty_in = 1'b1;
                  if (!match_failed_in && match_index_in < hcrs_pkg::TE_LEN &&
                      byte_ff == hcrs_pkg::te_char(match_index_in)) begin
                     match_index_in = match_index_in + 5'd1;
                  end else begin
                     match_failed_in = 1'b1;
                  end
                  res[n_res[0]] = '{byte_ff, 1'b1, 1'b0, 1'b0};
                  n_res         = n_res + 2'd1;
               end
            end
         end
         MODE_PLAIN: begin
            res[n_res[0]] = '{byte_ff, 1'b1, 1'b1, 1'b0};
            n_res         = n_res + 2'd1;
         end
         MODE_SIZE: begin
            if (size_line_cr_ff && byte_ff == hcrs_pkg::CH_LF) begin
               // Size line complete: start data or the final part
               size_accum_in   = '0;
               hex_done_in     = 1'b0;
               size_line_cr_in = 1'b0;
               if (size_accum_ff == '0) begin
                  mode_in = MODE_FINAL;
               end else begin
                  pass_count_in = {1'b0, size_accum_ff} +
                                  (SIZE_BITS+1)'(hcrs_pkg::CHUNK_TRAILER_LEN);
                  mode_in       = MODE_DATA;
               end
            end else if (byte_ff == hcrs_pkg::CH_CR) begin
               size_line_cr_in = 1'b1;
               hex_done_in     = 1'b1;
            end else begin
               size_line_cr_in = 1'b0;
               if (!hex_done_ff && hx.ok) begin
                  // Accumulate a hex digit, saturating
                  ext = {size_accum_ff, hx.value};
                  if (ext[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
                     size_accum_in = '1;
                  end else begin
                     size_accum_in = ext[SIZE_BITS-1:0];
                  end
               end else begin
                  hex_done_in = 1'b1;
               end
            end
         end
         MODE_DATA: begin
            do_fold = 1'b1;
            if (pc != '0) begin
               pc = pc - (SIZE_BITS+1)'(1);
            end
            pass_count_in = pc;
            if (pc == '0) begin
               mode_in         = MODE_SIZE;
               size_accum_in   = '0;
               hex_done_in     = 1'b0;
               size_line_cr_in = 1'b0;
            end
         end
         default: begin
            do_fold = 1'b1;
         end
      endcase

      // Fold CR LF to LF in chunk data and the final part
      if (do_fold) begin
         skip = 1'b0;
         if (held_cr_ff) begin
            held_cr_in = 1'b0;
            if (byte_ff == hcrs_pkg::CH_LF) begin
               res[n_res[0]] = '{hcrs_pkg::CH_LF, 1'b1, 1'b1, 1'b0};
               n_res         = n_res + 2'd1;
               skip          = 1'b1;
            end else begin
               res[n_res[0]] = '{hcrs_pkg::CH_CR, 1'b1, 1'b1, 1'b0};
               n_res         = n_res + 2'd1;
            end
         end
         if (!skip) begin
            if (byte_ff == hcrs_pkg::CH_CR) begin
               held_cr_in = 1'b1;
            end else begin
               res[n_res[0]] = '{byte_ff, 1'b1, 1'b1, 1'b0};
               n_res         = n_res + 2'd1;
            end
         end
      end

      // End of response: flush a held CR, mark the last result, reset state
      if (last_ff) begin
         part = (mode_in != MODE_HDR);
         if (held_cr_in) begin
            res[n_res[0]] = '{hcrs_pkg::CH_CR, 1'b1, part, 1'b0};
            n_res         = n_res + 2'd1;
         end
         if (n_res == 2'd0) begin
            res[0] = '{8'h00, 1'b0, part, 1'b0};
            n_res  = 2'd1;
         end
         res[n_res[1]].last = 1'b1;
         mode_in          = MODE_HDR;
         held_cr_in       = 1'b0;
         line_nonempty_in = 1'b0;
         match_index_in   = 5'd0;
         match_failed_in  = 1'b0;
         chunked_seen_in  = 1'b0;
         size_accum_in    = '0;
         hex_done_in      = 1'b0;
         size_line_cr_in  = 1'b0;
         pass_count_in    = '0;
      end
   end

   assign push_cnt = fire ? n_res : 2'd0;
   assign push0    = res[0];
   assign push1    = res[1];

   // Advance the framing state on each decoded word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_HDR;
         held_cr_ff       <= 1'b0;
         line_nonempty_ff <= 1'b0;
         match_index_ff   <= 5'd0;
         match_failed_ff  <= 1'b0;
         chunked_seen_ff  <= 1'b0;
         size_accum_ff    <= '0;
         hex_done_ff      <= 1'b0;
         size_line_cr_ff  <= 1'b0;
         pass_count_ff    <= '0;
      end else if (fire) begin
         mode_ff          <= mode_in;
         held_cr_ff       <= held_cr_in;
         line_nonempty_ff <= line_nonempty_in;
         match_index_ff   <= match_index_in;
         match_failed_ff  <= match_failed_in;
         chunked_seen_ff  <= chunked_seen_in;
         size_accum_ff    <= size_accum_in;
         hex_done_ff      <= hex_done_in;
         size_line_cr_ff  <= size_line_cr_in;
         pass_count_ff    <= pass_count_in;
      end
   end

   `HCRS_ASSERT_NEXT(a_last_clears_state, clock, reset, fire && last_ff, mode_ff == MODE_HDR && !held_cr_ff && !chunked_seen_ff, "state not cleared after last word")
   `HCRS_ASSERT_IMPL(a_last_tagged, clock, reset, fire && last_ff, (push_cnt == 2'd1 && push0.last) || (push_cnt == 2'd2 && push1.last), "last word produced no tagged result")
   `HCRS_ASSERT_IMPL(a_data_count_live, clock, reset, mode_ff == MODE_DATA, pass_count_ff != '0, "chunk data mode with zero byte count")

endmodule

[hw/rtl/hcrs_rsp_queue.sv]
// Four-entry result queue that takes up to two results per cycle while it has room for two more.
module hcrs_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_cnt,
   input  hcrs_pkg::result_type  push0,
   input  hcrs_pkg::result_type  push1,
   output logic                  space_ok,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hcrs_pkg::result_type  out_res
);

   localparam int PTR_BITS = $clog2(hcrs_pkg::RSP_DEPTH);
   localparam int CNT_BITS = $clog2(hcrs_pkg::RSP_DEPTH + 1);

   hcrs_pkg::result_type mem_ff [hcrs_pkg::RSP_DEPTH];
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  level;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_res   = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Room for two more results once this cycle's pop leaves
   assign level    = count_ff - CNT_BITS'(pop);
   assign space_ok = (level <= CNT_BITS'(hcrs_pkg::RSP_DEPTH - 2));

   // Advance pointers and occupancy
   always_comb begin
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_cnt);
      count_in  = level + CNT_BITS'(push_cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write one or two entries
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_BITS'(1)] <= push1;
      end
   end

endmodule

[hw/rtl/http_chunked_response_splitter.sv]
// Top level of the HTTP chunked response splitter.
// Takes one response byte per word on req_ and returns it tagged as header
// or body on rsp_, with CR LF folded to LF (a non-chunked body passes
// unchanged), chunk size lines removed and a final held CR flushed; each
// response ends with one rsp_tlast result (an empty marker with tuser
// byte_valid low if no byte is left). The block takes one word per clock
// while the result queue has room for two more results; a word that yields
// two results (a CR not followed by LF, or a CR flushed at the end) fills
// two places in the four-entry result queue, which the single output port
// drains. The input register holds each word while it is decoded, and its
// results then enter the queue and show on rsp_.
module http_chunked_response_splitter #(
   parameter int SIZE_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] out_part
   output logic       rsp_tlast
);

   logic                 space_ok;
   logic [1:0]           push_cnt;
   hcrs_pkg::result_type push0;
   hcrs_pkg::result_type push1;
   hcrs_pkg::result_type out_res;

   // Decode stage
   hcrs_core #(
      .SIZE_BITS (SIZE_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .space_ok (space_ok),
      .push_cnt (push_cnt),
      .push0    (push0),
      .push1    (push1)
   );

   // Result queue
   hcrs_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (push0),
      .push1     (push1),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = out_res.data;
   assign rsp_tuser = {out_res.part, out_res.byte_valid};
   assign rsp_tlast = out_res.last;

endmodule
